@@ rtl/htm_pkg.sv @@
// shared widths, constants, codes and channel payload types of the header telemetry monitor
package htm_pkg;

  localparam int MASK_W         = 8;
  localparam int SOURCE_W       = 4;
  localparam int WORD_W         = 32;
  localparam int SLOT_W         = 3;
  localparam int BYTE_W         = 8;
  localparam int DATUM_W        = 28;
  localparam int COUNT_W        = 32;
  localparam int SUM_W          = DATUM_W + COUNT_W;
  localparam int MEAN_FRAC_BITS = 8;
  localparam int MEAN_W         = DATUM_W + MEAN_FRAC_BITS;
  localparam int DIVD_W         = SUM_W + MEAN_FRAC_BITS;
  localparam int ITER_W         = $clog2(MEAN_W + 1);
  localparam int NUM_CH         = 3;
  localparam int CH_W           = 2;
  localparam int TEMP_W         = 16;

  // temperature field sits in bits 15..6 of the datum
  localparam int TEMP_LO        = 6;
  localparam int TEMP_HI        = 15;
  localparam int TEMP_PROD_W    = 27;
  localparam int TEMP_SCALE     = 100795;
  localparam int TEMP_ROUND     = 1024;
  localparam int TEMP_SHIFT     = 11;
  localparam int TEMP_OFFSET    = 27315;

  localparam logic [SLOT_W-1:0] SLOT_STATUS = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_GPS    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_MASER  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TE     = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_TEMP   = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_GPS    = 3'd2,
    KIND_MASER  = 3'd3,
    KIND_TE     = 3'd4,
    KIND_TEMP   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] source_id;
    logic [WORD_W-1:0]   status_word;
    logic [SLOT_W-1:0]   frame_slot;
  } in_item_t;

  typedef struct packed {
    kind_t                     word_kind;
    logic                      status_changed;
    logic [BYTE_W-1:0]         personality;
    logic [BYTE_W-1:0]         sticky_flags;
    logic [COUNT_W-1:0]        sample_count;
    logic [MEAN_W-1:0]         mean_fixed;
    logic [DATUM_W-1:0]        deviation;
    logic [DATUM_W-1:0]        max_deviation;
    logic signed [TEMP_W-1:0]  temperature_centi;
  } out_item_t;

endpackage

@@ rtl/htm_in_if.sv @@
// valid/ready channel carrying one header word item
interface htm_in_if;
  import htm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/htm_out_if.sv @@
// valid/ready channel carrying one telemetry result item
interface htm_out_if;
  import htm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/header_telemetry_monitor.sv @@
// header telemetry monitor: decodes header words and keeps offset channel statistics
//
// Usage: each transfer on in_ch carries one extended-header word, its frame
// slot and a source id; each input gives exactly one transfer on out_ch.
// cfg_we/cfg_wdata load the 8-bit ignore mask; write it only while idle.
// in_ch.ready is high only while the sequencer is idle, so one word is
// worked at a time.
// Status, ignored and unused slots go straight to the output step;
// temperature passes through a conversion step first. The GPS, maser and
// TE offset slots pass the accumulate, multiply and difference steps and
// then the shared restoring divider, which runs 28 steps for the deviation
// and 36 steps for the mean, one quotient bit a cycle, before the output
// step. A new word is taken only once the last one has left the sequence.
// The result sits in an output register, so the next word is taken while
// it waits; a stalled receiver holds the block in its final step until the
// register frees.
// Reset (synchronous, active low) clears the mask, all channel counts,
// sums and maxima, the held status, flags, personality and temperature.
module header_telemetry_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [htm_pkg::MASK_W-1:0] cfg_wdata,
  htm_in_if.sink                     in_ch,
  htm_out_if.source                  out_ch
);
  import htm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ACC     = 9'b000000010,
    S_MUL     = 9'b000000100,
    S_DIFF    = 9'b000001000,
    S_DEV     = 9'b000010000,
    S_DEVDONE = 9'b000100000,
    S_MEAN    = 9'b001000000,
    S_TEMP    = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [MASK_W-1:0]        mask_r, mask_nxt;
  logic [WORD_W-1:0]        word_r, word_nxt;
  logic [CH_W-1:0]          ch_r, ch_nxt;
  kind_t                    kind_r, kind_nxt;
  logic                     chg_r, chg_nxt;
  logic [WORD_W-1:0]        prev_status_r, prev_status_nxt;
  logic [BYTE_W-1:0]        pers_r, pers_nxt;
  logic [BYTE_W-1:0]        flags_r, flags_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [COUNT_W-1:0]       cnt_r [NUM_CH];
  logic [COUNT_W-1:0]       cnt_nxt [NUM_CH];
  logic [SUM_W-1:0]         sum_r [NUM_CH];
  logic [SUM_W-1:0]         sum_nxt [NUM_CH];
  logic [DATUM_W-1:0]       maxdev_r [NUM_CH];
  logic [DATUM_W-1:0]       maxdev_nxt [NUM_CH];
  logic [COUNT_W-1:0]       cnt_w_r, cnt_w_nxt;
  logic [SUM_W-1:0]         sum_w_r, sum_w_nxt;
  logic [SUM_W-1:0]         prod_r, prod_nxt;
  logic [COUNT_W-1:0]       rem_r, rem_nxt;
  logic [DIVD_W-1:0]        quo_r, quo_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic [DATUM_W-1:0]       dev_r, dev_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     in_fire;
  logic [DATUM_W-1:0]       datum;
  logic [SUM_W-1:0]         mul_res;
  logic [SUM_W-1:0]         diff;
  logic [DIVD_W-1:0]        mean_divd;
  logic [COUNT_W:0]         trial;
  logic [COUNT_W:0]         trial_sub;
  logic                     trial_ge;
  logic [COUNT_W-1:0]       rem_step;
  logic [DIVD_W-1:0]        quo_step;
  logic [TEMP_PROD_W-1:0]   temp_prod;
  logic [TEMP_PROD_W-1:0]   temp_sum;
  logic [TEMP_W-1:0]        temp_k;
  logic                     is_chan;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign datum     = word_r[DATUM_W-1:0];
  assign mul_res   = datum * cnt_w_r;
  assign diff      = (prod_r >= sum_w_r) ? (prod_r - sum_w_r) : (sum_w_r - prod_r);
  assign mean_divd = {sum_w_r, {MEAN_FRAC_BITS{1'b0}}};

  // one restoring step of the shared divider, divisor is the channel count
  assign trial     = {rem_r, quo_r[DIVD_W-1]};
  assign trial_sub = trial - {1'b0, cnt_w_r};
  assign trial_ge  = (trial >= {1'b0, cnt_w_r});
  assign rem_step  = trial_ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
  assign quo_step  = {quo_r[DIVD_W-2:0], trial_ge};

  assign temp_prod = TEMP_PROD_W'(word_r[TEMP_HI:TEMP_LO]) * TEMP_PROD_W'(TEMP_SCALE);
  assign temp_sum  = temp_prod + TEMP_PROD_W'(TEMP_ROUND);
  assign temp_k    = temp_sum[TEMP_SHIFT +: TEMP_W];

  assign is_chan = (kind_r == KIND_GPS) || (kind_r == KIND_MASER) || (kind_r == KIND_TE);

  always_comb begin
    state_nxt       = state_r;
    mask_nxt        = mask_r;
    word_nxt        = word_r;
    ch_nxt          = ch_r;
    kind_nxt        = kind_r;
    chg_nxt         = chg_r;
    prev_status_nxt = prev_status_r;
    pers_nxt        = pers_r;
    flags_nxt       = flags_r;
    temp_nxt        = temp_r;
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    maxdev_nxt      = maxdev_r;
    cnt_w_nxt       = cnt_w_r;
    sum_w_nxt       = sum_w_r;
    prod_nxt        = prod_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    iter_nxt        = iter_r;
    dev_nxt         = dev_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_data_nxt    = out_data_r;

    if (cfg_we) begin
      mask_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          word_nxt  = in_ch.data.status_word;
          ch_nxt    = in_ch.data.frame_slot[CH_W-1:0] - CH_W'(1);
          chg_nxt   = 1'b0;
          kind_nxt  = KIND_NONE;
          state_nxt = S_OUT;
          if (!mask_r[in_ch.data.frame_slot]) begin
            case (in_ch.data.frame_slot)
              SLOT_STATUS: begin
                kind_nxt  = KIND_STATUS;
                pers_nxt  = in_ch.data.status_word[WORD_W-1 -: BYTE_W];
                flags_nxt = flags_r | in_ch.data.status_word[BYTE_W-1:0];
                if (in_ch.data.status_word != prev_status_r) begin
                  prev_status_nxt = in_ch.data.status_word;
                  chg_nxt         = 1'b1;
                end
              end
              SLOT_GPS: begin
                kind_nxt  = KIND_GPS;
                state_nxt = S_ACC;
              end
              SLOT_MASER: begin
                kind_nxt  = KIND_MASER;
                state_nxt = S_ACC;
              end
              SLOT_TE: begin
                kind_nxt  = KIND_TE;
                state_nxt = S_ACC;
              end
              SLOT_TEMP: begin
                kind_nxt  = KIND_TEMP;
                state_nxt = S_TEMP;
              end
              default: begin
                kind_nxt = KIND_NONE;
              end
            endcase
          end
        end
      end
      S_ACC: begin
        // count and sum freeze once the count saturates
        if (cnt_r[ch_r] != {COUNT_W{1'b1}}) begin
          cnt_nxt[ch_r] = cnt_r[ch_r] + COUNT_W'(1);
          sum_nxt[ch_r] = sum_r[ch_r] + SUM_W'(datum);
          cnt_w_nxt     = cnt_r[ch_r] + COUNT_W'(1);
          sum_w_nxt     = sum_r[ch_r] + SUM_W'(datum);
        end else begin
          cnt_w_nxt = cnt_r[ch_r];
          sum_w_nxt = sum_r[ch_r];
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_res;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        // quotient |datum*count - sum| / count fits the datum width
        rem_nxt   = diff[SUM_W-1 -: COUNT_W];
        quo_nxt   = {diff[DATUM_W-1:0], {(DIVD_W - DATUM_W){1'b0}}};
        iter_nxt  = ITER_W'(DATUM_W);
        state_nxt = S_DEV;
      end
      S_DEV: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        iter_nxt = iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          state_nxt = S_DEVDONE;
        end
      end
      S_DEVDONE: begin
        dev_nxt = quo_r[DATUM_W-1:0];
        if (quo_r[DATUM_W-1:0] > maxdev_r[ch_r]) begin
          maxdev_nxt[ch_r] = quo_r[DATUM_W-1:0];
        end
        rem_nxt   = mean_divd[DIVD_W-1 -: COUNT_W];
        quo_nxt   = {mean_divd[MEAN_W-1:0], {COUNT_W{1'b0}}};
        iter_nxt  = ITER_W'(MEAN_W);
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        iter_nxt = iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_TEMP: begin
        temp_nxt  = signed'(temp_k - TEMP_W'(TEMP_OFFSET));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.word_kind         = kind_r;
          out_data_nxt.status_changed    = chg_r;
          out_data_nxt.personality       = pers_r;
          out_data_nxt.sticky_flags      = flags_r;
          out_data_nxt.temperature_centi = temp_r;
          if (is_chan) begin
            out_data_nxt.sample_count  = cnt_w_r;
            out_data_nxt.mean_fixed    = quo_r[MEAN_W-1:0];
            out_data_nxt.deviation     = dev_r;
            out_data_nxt.max_deviation = maxdev_r[ch_r];
          end else begin
            out_data_nxt.sample_count  = '0;
            out_data_nxt.mean_fixed    = '0;
            out_data_nxt.deviation     = '0;
            out_data_nxt.max_deviation = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mask_r        <= '0;
      prev_status_r <= '0;
      pers_r        <= '0;
      flags_r       <= '0;
      temp_r        <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        cnt_r[i]    <= '0;
        sum_r[i]    <= '0;
        maxdev_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      mask_r        <= mask_nxt;
      prev_status_r <= prev_status_nxt;
      pers_r        <= pers_nxt;
      flags_r       <= flags_nxt;
      temp_r        <= temp_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
      sum_r         <= sum_nxt;
      maxdev_r      <= maxdev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    ch_r       <= ch_nxt;
    kind_r     <= kind_nxt;
    chg_r      <= chg_nxt;
    cnt_w_r    <= cnt_w_nxt;
    sum_w_r    <= sum_w_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    iter_r     <= iter_nxt;
    dev_r      <= dev_nxt;
    out_data_r <= out_data_nxt;
  end

  // partial remainder must stay below the divisor for the quotient to be exact
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEV || state_r == S_MEAN) |-> (rem_r < cnt_w_r))
    else $error("divider remainder not below channel count");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the final step");

  a_dev_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.word_kind == KIND_GPS || out_data_r.word_kind == KIND_MASER ||
     out_data_r.word_kind == KIND_TE)) |->
    (out_data_r.deviation <= out_data_r.max_deviation && out_data_r.sample_count != '0))
    else $error("channel result with deviation above maximum or zero count");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !(out_data_r.word_kind == KIND_GPS || out_data_r.word_kind == KIND_MASER ||
     out_data_r.word_kind == KIND_TE)) |->
    (out_data_r.sample_count == '0 && out_data_r.mean_fixed == '0 &&
     out_data_r.deviation == '0 && out_data_r.max_deviation == '0))
    else $error("channel fields set on a non-channel result");

endmodule

@@ tb/sv/tb.sv @@
// testbench for header_telemetry_monitor: directed and random header words checked against a local model
`timescale 1ns / 100ps

module tb;
  import htm_pkg::*;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [MASK_W-1:0]   cfg_wdata;

  htm_in_if  in_ch ();
  htm_out_if out_ch ();

  header_telemetry_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // model state of the monitor
  logic [MASK_W-1:0]        mask_model;
  logic [WORD_W-1:0]        model_status;
  logic [BYTE_W-1:0]        held_pers;
  logic [BYTE_W-1:0]        held_flags;
  logic [COUNT_W-1:0]       chan_count [NUM_CH];
  logic [63:0]              chan_sum [NUM_CH];
  logic [DATUM_W-1:0]       chan_peak [NUM_CH];
  logic signed [TEMP_W-1:0] held_temp;

  out_item_t          pending_telemetry [$];
  logic [DATUM_W-1:0] chan_center [NUM_CH];

  int           mismatch_count = 0;
  int           burst_left     = 0;
  bit           sender_gaps    = 1'b1;
  int           hold_request   = 0;
  stall_style_t ready_style    = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("header_telemetry_monitor: mismatch");
    $finish;
  end

  function automatic out_item_t decode_header_word(in_item_t w);
    out_item_t          r;
    logic [DATUM_W-1:0] datum;
    int                 ch;
    logic [63:0]        cnt;
    logic [63:0]        prod;
    logic [63:0]        diff;
    logic [63:0]        quot;
    logic [63:0]        rem;
    logic [DATUM_W-1:0] dev;
    logic [9:0]         code;
    logic [31:0]        kelvin;
    r = '0;
    datum = w.status_word[DATUM_W-1:0];
    if (!mask_model[w.frame_slot]) begin
      if (w.frame_slot == SLOT_STATUS) begin
        r.word_kind = KIND_STATUS;
        held_pers = w.status_word[31:24];
        held_flags |= w.status_word[7:0];
        if (w.status_word != model_status) begin
          model_status = w.status_word;
          r.status_changed = 1'b1;
        end
      end else if (w.frame_slot <= SLOT_TE) begin
        ch = int'(w.frame_slot) - int'(SLOT_GPS);
        case (w.frame_slot)
          SLOT_GPS:   r.word_kind = KIND_GPS;
          SLOT_MASER: r.word_kind = KIND_MASER;
          default:    r.word_kind = KIND_TE;
        endcase
        // a saturated channel keeps its count and sum frozen
        if (chan_count[ch] != '1) begin
          chan_count[ch]++;
          chan_sum[ch] += 64'(datum);
        end
        cnt  = 64'(chan_count[ch]);
        prod = 64'(datum) * cnt;
        diff = (prod >= chan_sum[ch]) ? prod - chan_sum[ch] : chan_sum[ch] - prod;
        dev  = DATUM_W'(diff / cnt);
        if (dev > chan_peak[ch]) chan_peak[ch] = dev;
        quot = chan_sum[ch] / cnt;
        rem  = chan_sum[ch] % cnt;
        r.sample_count  = chan_count[ch];
        r.mean_fixed    = MEAN_W'((quot << MEAN_FRAC_BITS) + ((rem << MEAN_FRAC_BITS) / cnt));
        r.deviation     = dev;
        r.max_deviation = chan_peak[ch];
      end else if (w.frame_slot == SLOT_TEMP) begin
        // 503.975/1024 degrees per code, minus 273.15, in hundredths rounded half up
        code      = datum[15:6];
        kelvin    = (32'(code) * 32'd100795 + 32'd1024) / 32'd2048;
        held_temp = TEMP_W'(kelvin - 32'd27315);
        r.word_kind = KIND_TEMP;
      end
    end
    r.personality       = held_pers;
    r.sticky_flags      = held_flags;
    r.temperature_centi = held_temp;
    return r;
  endfunction

  function automatic in_item_t random_word();
    in_item_t           w;
    int                 pick;
    int                 ch;
    int                 spread;
    logic [DATUM_W-1:0] offset;
    w.source_id   = SOURCE_W'($urandom);
    w.status_word = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      w.frame_slot = SLOT_STATUS;
      if ($urandom_range(0, 2) == 0) w.status_word = model_status;
    end else if (pick < 70) begin
      ch = $urandom_range(0, NUM_CH - 1);
      w.frame_slot = SLOT_W'(int'(SLOT_GPS) + ch);
      spread = $urandom_range(0, 20);
      offset = DATUM_W'($urandom & ((32'd1 << spread) - 32'd1));
      // top nibble stays random so the datum masking is exercised
      case ($urandom_range(0, 9))
        0:       w.status_word[DATUM_W-1:0] = '0;
        1:       w.status_word[DATUM_W-1:0] = '1;
        2, 3:    ;
        default: w.status_word[DATUM_W-1:0] = $urandom_range(0, 1) ?
                   chan_center[ch] + offset : chan_center[ch] - offset;
      endcase
    end else if (pick < 88) begin
      w.frame_slot = SLOT_TEMP;
    end else begin
      w.frame_slot = SLOT_W'($urandom_range(int'(SLOT_TEMP) + 1, 2**SLOT_W - 1));
    end
    return w;
  endfunction

  task automatic send_word(input logic [SOURCE_W-1:0] src, input logic [WORD_W-1:0] word,
                           input logic [SLOT_W-1:0] slot);
    in_item_t item;
    int       pick;
    int       gap;
    item.source_id   = src;
    item.status_word = word;
    item.frame_slot  = slot;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pick = $urandom_range(0, 19);
      gap = (pick < 8)  ? $urandom_range(0, 4) :
            (pick < 17) ? $urandom_range(5, 30) : $urandom_range(31, 90);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_telemetry.push_back(decode_header_word(item));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_telemetry.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mask(input logic [MASK_W-1:0] m);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mask_model = m;
  endtask

  task automatic run_random_words(input int target);
    in_item_t w;
    repeat (target) begin
      w = random_word();
      send_word(w.source_id, w.status_word, w.frame_slot);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin : receiver
    int   run_left;
    logic run_ready;
    int   hold_left;
    run_left  = 0;
    run_ready = 1'b1;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (ready_style)
          STALL_NONE:   out_ch.ready <= 1'b1;
          STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (run_left == 0) begin
              run_ready = ($urandom_range(0, 4) < 3);
              run_left  = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 90);
            end
            run_left--;
            out_ch.ready <= run_ready;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_telemetry
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_telemetry.size() == 0) begin
        note_mismatch("transfer with nothing expected, word_kind", '0, 64'(got.word_kind));
      end else begin
        want = pending_telemetry.pop_front();
        if (got.word_kind !== want.word_kind)
          note_mismatch("word_kind", 64'(want.word_kind), 64'(got.word_kind));
        if (got.status_changed !== want.status_changed)
          note_mismatch("status_changed", 64'(want.status_changed), 64'(got.status_changed));
        if (got.personality !== want.personality)
          note_mismatch("personality", 64'(want.personality), 64'(got.personality));
        if (got.sticky_flags !== want.sticky_flags)
          note_mismatch("sticky_flags", 64'(want.sticky_flags), 64'(got.sticky_flags));
        if (got.sample_count !== want.sample_count)
          note_mismatch("sample_count", 64'(want.sample_count), 64'(got.sample_count));
        if (got.mean_fixed !== want.mean_fixed)
          note_mismatch("mean_fixed", 64'(want.mean_fixed), 64'(got.mean_fixed));
        if (got.deviation !== want.deviation)
          note_mismatch("deviation", 64'(want.deviation), 64'(got.deviation));
        if (got.max_deviation !== want.max_deviation)
          note_mismatch("max_deviation", 64'(want.max_deviation), 64'(got.max_deviation));
        if (got.temperature_centi !== want.temperature_centi)
          note_mismatch("temperature_centi", 64'(want.temperature_centi),
                        64'(got.temperature_centi));
      end
    end
  end

  task automatic test_directed();
    ready_style = STALL_RUNS;
    sender_gaps = 1'b1;
    // a first status of zero matches the cleared previous word
    send_word(4'd0,  32'h0000_0000, SLOT_STATUS);
    send_word(4'd15, 32'hFFFF_FFFF, SLOT_STATUS);
    send_word(4'd3,  32'hFFFF_FFFF, SLOT_STATUS);
    send_word(4'd9,  32'h0000_0000, SLOT_STATUS);
    send_word(4'd1,  32'h0000_0000, SLOT_GPS);
    send_word(4'd2,  32'hFFFF_FFFF, SLOT_GPS);
    send_word(4'd4,  32'hF000_0000, SLOT_GPS);
    send_word(4'd5,  32'h0FFF_FFFF, SLOT_MASER);
    send_word(4'd6,  32'h0FFF_FFFF, SLOT_MASER);
    send_word(4'd7,  32'h0000_0001, SLOT_TE);
    send_word(4'd8,  32'h0FFF_FFFF, SLOT_TE);
    // temperature code extremes, with junk outside the field
    send_word(4'd10, 32'h0000_0000, SLOT_TEMP);
    send_word(4'd11, 32'h0000_FFC0, SLOT_TEMP);
    send_word(4'd12, 32'hFFFF_003F, SLOT_TEMP);
    send_word(4'd13, 32'h0000_8000, SLOT_TEMP);
    for (int s = int'(SLOT_TEMP) + 1; s < 2**SLOT_W; s++)
      send_word(SOURCE_W'($urandom), $urandom, SLOT_W'(s));
  endtask

  task automatic test_ignore_mask();
    ready_style = STALL_RANDOM;
    set_mask(8'hFF);
    for (int s = 0; s < 2**SLOT_W; s++)
      send_word(SOURCE_W'($urandom), $urandom | 32'h0101_FFC0, SLOT_W'(s));
    set_mask(8'h55);
    repeat (16) send_word(SOURCE_W'($urandom), $urandom, SLOT_W'($urandom));
    set_mask(8'hAA);
    repeat (16) send_word(SOURCE_W'($urandom), $urandom, SLOT_W'($urandom));
    set_mask(8'h00);
  endtask

  task automatic test_backpressure();
    in_item_t w;
    ready_style = STALL_NONE;
    sender_gaps = 1'b0;
    drain_results();
    // receiver holds off while the sender keeps offering, so the input stalls
    hold_request = 400;
    repeat (40) begin
      w = random_word();
      send_word(w.source_id, w.status_word, w.frame_slot);
    end
    drain_results();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < NUM_CH; i++) chan_center[i] = DATUM_W'($urandom);
    ready_style = STALL_RUNS;
    set_mask(8'h00);
    run_random_words(350);
    ready_style = STALL_RANDOM;
    set_mask(MASK_W'($urandom) & 8'hFE);
    run_random_words(200);
    // a stretch with no idling on either side
    ready_style = STALL_NONE;
    sender_gaps = 1'b0;
    set_mask(8'h00);
    run_random_words(200);
    sender_gaps = 1'b1;
    ready_style = STALL_RUNS;
    set_mask(8'hE0);
    run_random_words(200);
    ready_style = STALL_RANDOM;
    set_mask(MASK_W'($urandom) & 8'hFE);
    run_random_words(150);
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    mask_model   = '0;
    model_status = '0;
    held_pers    = '0;
    held_flags   = '0;
    held_temp    = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_count[i]  = '0;
      chan_sum[i]    = '0;
      chan_peak[i]   = '0;
      chan_center[i] = DATUM_W'($urandom);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ignore_mask();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_telemetry.size() == 0) begin
      $display("header_telemetry_monitor: match");
    end else begin
      $display("header_telemetry_monitor: mismatch");
    end
    $finish;
  end

endmodule
